FILE: rtl/core/u2c_pkg.sv
// u2c_pkg: shared types and constants for the unix time to calendar block
// used by u2c_ctrl, u2c_dp, unix_time_to_calendar and tb_top; no dependencies
package u2c_pkg;

	// conversion limits and calendar constants
	localparam logic [31:0] TS_LIMIT     = 32'd2147483000;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [16:0] SECS_PER_HR  = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN = 17'd60;
	localparam logic [10:0] EPOCH_YEAR   = 11'd1970;
	localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
	localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
	localparam logic [8:0]  DAYS_LEAP    = 9'd366;
	localparam logic [8:0]  DAYS_COMMON  = 9'd365;
	localparam logic [3:0]  MONTH_JAN    = 4'd1;
	localparam logic [3:0]  MONTH_FEB    = 4'd2;
	localparam logic [3:0]  MONTH_DEC    = 4'd12;

	// reciprocals for the constant divisions, rounded up, exact over the operand range
	// days: (ts >> 7) / 675 as a product shifted down by 35
	// hours: (sod >> 4) / 225 as a product shifted down by 21
	// minutes: (rem >> 2) / 15 as a product shifted down by 14
	localparam logic [25:0] RECIP_DAY = 26'd50903317;
	localparam logic [13:0] RECIP_HR  = 14'd9321;
	localparam logic [10:0] RECIP_MIN = 11'd1093;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DAYQ,
		OP_SOD,
		OP_HRQ,
		OP_MINR,
		OP_MINQ,
		OP_SEC,
		OP_YEAR,
		OP_MONTH,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic ok;
		logic year_done;
		logic month_done;
	} sts_t;

	// days in a common-year month
	function automatic logic [4:0] month_len(input logic [3:0] mon);
		logic [4:0] len;
		begin
			unique case (mon)
				4'd2:                   len = 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				default:                len = 5'd31;
			endcase
			return len;
		end
	endfunction

endpackage

FILE: rtl/core/u2c_dp.sv
// u2c_dp: datapath with reciprocal multipliers for the constant divisions,
// year and month steppers, and the result register; depends on u2c_pkg
module u2c_dp import u2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [31:0] timestamp,
	output logic        ok,
	output logic [10:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	logic [31:0] ts_q;
	logic [14:0] days_q;
	logic [16:0] sod_q;
	logic [11:0] rem_q;
	logic [10:0] year_q;
	logic [6:0]  mod100_q;
	logic [8:0]  mod400_q;
	logic [3:0]  mon_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	logic        ok_q;

	logic [50:0] day_prod;
	logic [16:0] day_secs;
	logic [26:0] hr_prod;
	logic [11:0] hr_secs;
	logic [20:0] min_prod;
	logic [5:0]  min_secs;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	// quotients by reciprocal multiplication, remainders kept modulo their range
	always_comb begin
		day_prod = {26'd0, ts_q[31:7]} * {25'd0, RECIP_DAY};
		day_secs = {2'd0, days_q} * SECS_PER_DAY;
		hr_prod  = {14'd0, sod_q[16:4]} * {13'd0, RECIP_HR};
		hr_secs  = {7'd0, hour_q} * SECS_PER_HR[11:0];
		min_prod = {11'd0, rem_q[11:2]} * {10'd0, RECIP_MIN};
		min_secs = min_q * SECS_PER_MIN[5:0];
	end

	// full gregorian leap rule from running year residues
	always_comb begin
		leap = (year_q[1:0] == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
		ylen = leap ? DAYS_LEAP : DAYS_COMMON;
		mlen = month_len(mon_q) + {4'd0, (mon_q == MONTH_FEB) && leap};
	end

	assign sts.ok         = ok_q;
	assign sts.year_done  = {1'b0, days_q} < {7'd0, ylen};
	assign sts.month_done = (days_q < {10'd0, mlen}) || (mon_q >= MONTH_DEC);

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ts_q     <= timestamp;
				year_q   <= EPOCH_YEAR;
				mod100_q <= EPOCH_MOD100;
				mod400_q <= EPOCH_MOD400;
				mon_q    <= MONTH_JAN;
			end
			OP_DAYQ: begin
				days_q <= day_prod[49:35];
			end
			OP_SOD: begin
				sod_q <= ts_q[16:0] - day_secs;
			end
			OP_HRQ: begin
				hour_q <= hr_prod[25:21];
			end
			OP_MINR: begin
				rem_q <= sod_q[11:0] - hr_secs;
			end
			OP_MINQ: begin
				min_q <= min_prod[19:14];
			end
			OP_SEC: begin
				sec_q <= rem_q[5:0] - min_secs;
			end
			OP_YEAR: begin
				if (!sts.year_done) begin
					days_q   <= days_q - {6'd0, ylen};
					year_q   <= year_q + 11'd1;
					mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
					mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
				end
			end
			OP_MONTH: begin
				if (!sts.month_done) begin
					days_q <= days_q - {10'd0, mlen};
					mon_q  <= mon_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// range check flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (cmd.op == OP_LOAD) begin
			ok_q <= timestamp <= TS_LIMIT;
		end
	end

	// result register, zeroed on reject
	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			ok     <= ok_q;
			year   <= ok_q ? year_q : '0;
			month  <= ok_q ? mon_q : '0;
			day    <= ok_q ? days_q[4:0] + 5'd1 : '0;
			hour   <= ok_q ? hour_q : '0;
			minute <= ok_q ? min_q : '0;
			second <= ok_q ? sec_q : '0;
		end
	end

endmodule

FILE: rtl/core/u2c_ctrl.sv
// u2c_ctrl: one-hot controller sequencing the conversion steps
// and the input and output handshakes; depends on u2c_pkg
module u2c_ctrl import u2c_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DAYQ  = 10'b0000000010,
		S_SOD   = 10'b0000000100,
		S_HRQ   = 10'b0000001000,
		S_MINR  = 10'b0000010000,
		S_MINQ  = 10'b0000100000,
		S_SEC   = 10'b0001000000,
		S_YEAR  = 10'b0010000000,
		S_MONTH = 10'b0100000000,
		S_EMIT  = 10'b1000000000
	} state_t;

	state_t     state_q, state_d;
	logic       out_valid_q;
	logic       emit;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DAYQ;
				end
			end
			S_DAYQ: begin
				if (!sts.ok) begin
					state_d = S_EMIT;
				end else begin
					cmd.op  = OP_DAYQ;
					state_d = S_SOD;
				end
			end
			S_SOD: begin
				cmd.op  = OP_SOD;
				state_d = S_HRQ;
			end
			S_HRQ: begin
				cmd.op  = OP_HRQ;
				state_d = S_MINR;
			end
			S_MINR: begin
				cmd.op  = OP_MINR;
				state_d = S_MINQ;
			end
			S_MINQ: begin
				cmd.op  = OP_MINQ;
				state_d = S_SEC;
			end
			S_SEC: begin
				cmd.op  = OP_SEC;
				state_d = S_YEAR;
			end
			S_YEAR: begin
				cmd.op = OP_YEAR;
				if (sts.year_done) begin
					state_d = S_MONTH;
				end
			end
			S_MONTH: begin
				cmd.op = OP_MONTH;
				if (sts.month_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/unix_time_to_calendar.sv
// unix_time_to_calendar: 32-bit unix timestamp to gregorian date and time of day
// accept loads the timestamp, then six multiply steps, the year and month loops (one step
// a cycle) and the result load, which waits for a free output; rejects skip from the day
// step to it; one transaction at a time, next accept in the cycle after the result loads
// reset: arst_n asynchronous active low, clears controller, output valid and range flag only
// depends on u2c_pkg, u2c_ctrl, u2c_dp
module unix_time_to_calendar import u2c_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] timestamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [10:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	u2c_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and result register
	u2c_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.timestamp (timestamp),
		.ok        (ok),
		.year      (year),
		.month     (month),
		.day       (day),
		.hour      (hour),
		.minute    (minute),
		.second    (second)
	);

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for unix_time_to_calendar, unix time to calendar date
// depends on u2c_pkg for the range limit and calendar constants, and on the rtl top level
`timescale 1ns / 100ps

module tb_top;
	import u2c_pkg::*;

	localparam int unsigned RANDOM_ITEMS   = 1800;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned IDLE_LIMIT     = 4000;
	localparam int unsigned DRAIN_CYCLES   = 120;

	// one converted date and time, laid out like the result ports
	typedef struct packed {
		logic        ok;
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_t;

	typedef struct packed {
		logic [31:0] ts;
		cal_t        cal;
	} dated_ts_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] timestamp = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ok;
	logic [10:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	logic [31:0]  ts_pending[$];
	dated_ts_t    dates_due[$];
	int unsigned  items_total = 0;
	int unsigned  items_sent = 0;
	int unsigned  results_seen = 0;
	int unsigned  rejects_seen = 0;
	int unsigned  holds_done = 0;
	int unsigned  mismatches = 0;

	unix_time_to_calendar dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.timestamp (timestamp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ok        (ok),
		.year      (year),
		.month     (month),
		.day       (day),
		.hour      (hour),
		.minute    (minute),
		.second    (second)
	);

	// gregorian leap rule
	function automatic bit is_leap(input int unsigned yr);
		return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
	endfunction

	// expected calendar fields for one timestamp
	function automatic cal_t calendar_of(input logic [31:0] ts);
		cal_t        res;
		int unsigned days;
		int unsigned sod;
		int unsigned yr;
		int unsigned mo;
		int unsigned ylen;
		int unsigned mlen;
		res = '0;
		if (ts > TS_LIMIT) begin
			return res;
		end
		days = ts / SECS_PER_DAY;
		sod = ts % SECS_PER_DAY;
		// walk whole years from the epoch
		yr = EPOCH_YEAR;
		ylen = is_leap(yr) ? DAYS_LEAP : DAYS_COMMON;
		while (days >= ylen) begin
			days -= ylen;
			yr++;
			ylen = is_leap(yr) ? DAYS_LEAP : DAYS_COMMON;
		end
		// walk months, december takes whatever is left
		mo = 1;
		forever begin
			if (mo == 2)
				mlen = is_leap(yr) ? 29 : 28;
			else if (mo == 4 || mo == 6 || mo == 9 || mo == 11)
				mlen = 30;
			else
				mlen = 31;
			if (days < mlen || mo >= 12)
				break;
			days -= mlen;
			mo++;
		end
		res.ok = 1'b1;
		res.year = yr[10:0];
		res.month = mo[3:0];
		res.day = 5'(days + 1);
		res.hour = 5'(sod / SECS_PER_HR);
		res.minute = 6'((sod % SECS_PER_HR) / SECS_PER_MIN);
		res.second = 6'(sod % SECS_PER_MIN);
		return res;
	endfunction

	// idle length: mostly short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 45)
			return 0;
		if (roll < 80)
			return $urandom_range(3, 1);
		if (roll < 95)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] ts,
			input int unsigned got, input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("ts %0d %s got %0d expected %0d",
				ts, name, got, want));
	endtask

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// driver: offers pending timestamps with random gaps between them
	int unsigned send_gap = 0;
	int unsigned send_calm = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			timestamp <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				dates_due.push_back('{ts: timestamp, cal: calendar_of(timestamp)});
				items_sent <= items_sent + 1;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (ts_pending.size() > 0) begin
					in_valid <= 1'b1;
					timestamp <= ts_pending.pop_front();
					if (send_calm > 0) begin
						send_calm <= send_calm - 1;
						send_gap <= 0;
					end else begin
						if ($urandom_range(99, 0) < 3)
							send_calm <= $urandom_range(80, 30);
						send_gap <= pick_gap();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction, drives random stalls and long hold-offs
	int unsigned stall_left = 0;
	int unsigned stall_calm = 0;
	int unsigned hold_left = 0;
	int unsigned next_hold_at = 300;

	always @(posedge clk or negedge arst_n) begin
		dated_ts_t due;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (dates_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing outstanding, year %0d",
						year));
				end else begin
					due = dates_due.pop_front();
					if (!ok)
						rejects_seen <= rejects_seen + 1;
					compare_field("ok", due.ts, ok, due.cal.ok);
					compare_field("year", due.ts, year, due.cal.year);
					compare_field("month", due.ts, month, due.cal.month);
					compare_field("day", due.ts, day, due.cal.day);
					compare_field("hour", due.ts, hour, due.cal.hour);
					compare_field("minute", due.ts, minute, due.cal.minute);
					compare_field("second", due.ts, second, due.cal.second);
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (results_seen >= next_hold_at) begin
				// long hold-off so the block backs up and stalls its input
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				next_hold_at <= next_hold_at + 900;
				holds_done <= holds_done + 1;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				if (stall_calm > 0) begin
					stall_calm <= stall_calm - 1;
				end else begin
					if ($urandom_range(99, 0) < 2)
						stall_calm <= $urandom_range(150, 50);
					stall_left <= pick_gap();
				end
			end
		end
	end

	// watchdog: ends the run after too long without any transaction
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned roll;
		int unsigned day_idx;
		logic [31:0] ts;
		arst_n = 1'b0;

		// directed: epoch, day and year edges, leap days, range limit, top bits
		ts_pending.push_back(32'd0);
		ts_pending.push_back(32'd86399);
		ts_pending.push_back(32'd86400);
		ts_pending.push_back(32'd31535999);
		ts_pending.push_back(32'd31536000);
		ts_pending.push_back(32'd68169600);
		ts_pending.push_back(32'd68256000);
		ts_pending.push_back(32'd94694399);
		ts_pending.push_back(32'd94694400);
		ts_pending.push_back(32'd946684799);
		ts_pending.push_back(32'd946684800);
		ts_pending.push_back(32'd951782400);
		ts_pending.push_back(32'd951868800);
		ts_pending.push_back(32'd1234567890);
		ts_pending.push_back(32'h5555_5555);
		ts_pending.push_back(32'd2147471999);
		ts_pending.push_back(32'd2147472000);
		ts_pending.push_back(TS_LIMIT - 1);
		ts_pending.push_back(TS_LIMIT);
		ts_pending.push_back(TS_LIMIT + 1);
		ts_pending.push_back(32'h7FFF_FFFF);
		ts_pending.push_back(32'h8000_0000);
		ts_pending.push_back(32'hAAAA_AAAA);
		ts_pending.push_back(32'hFFFF_FFFF);

		// random: mostly valid dates, with day edges, the range limit and rejects mixed in
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(99, 0);
			if (roll < 58) begin
				ts = $urandom_range(TS_LIMIT, 0);
			end else if (roll < 74) begin
				day_idx = $urandom_range(24855, 0);
				case ($urandom_range(2, 0))
					0: ts = day_idx * SECS_PER_DAY;
					1: ts = day_idx * SECS_PER_DAY + SECS_PER_DAY - 1;
					default: ts = day_idx * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1, 0);
				endcase
			end else if (roll < 82) begin
				ts = TS_LIMIT - 200 + $urandom_range(400, 0);
			end else if (roll < 91) begin
				ts = $urandom_range(32'h7FFF_FFFF, TS_LIMIT + 1);
			end else begin
				ts = $urandom | 32'h8000_0000;
			end
			ts_pending.push_back(ts);
		end
		items_total = ts_pending.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		wait (items_sent == items_total && results_seen == items_total);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d conversions, %0d of them rejected timestamps,", results_seen,
			rejects_seen);
		$display("under random input gaps and output stalls with %0d long output hold-offs",
			holds_done);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
